[rtl/aae_pkg.sv]
// ----------------------------------------------------------------------------
// aae_pkg
// Shared types and constants of the adaptive arithmetic encoder.
// ----------------------------------------------------------------------------
package aae_pkg;

  localparam int MAX_SYMBOLS_DEF  = 256;
  localparam int WORD_BITS_DEF    = 64;
  localparam int SYMBOL_COUNT_RST = 256;
  localparam int MIN_SYMBOLS      = 2;

  localparam int SYM_W    = 8;
  localparam int FREQ_W   = 14;
  localparam int BOUND_W  = 16;
  localparam int RANGE_W  = 17;
  localparam int PROD_W   = RANGE_W + FREQ_W;
  localparam int USED_W   = 7;
  localparam int CODE_W   = 64;
  localparam int GUARD_W  = 6;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int CNT_IN_W = 9;

  localparam logic [FREQ_W-1:0]  FREQ_LIMIT = 14'd16383;
  localparam logic [BOUND_W-1:0] TOP_VAL    = 16'hFFFF;
  localparam logic [BOUND_W-1:0] QTR1       = 16'h4000;
  localparam logic [BOUND_W-1:0] HALF_VAL   = 16'h8000;
  localparam logic [BOUND_W-1:0] QTR3       = 16'hC000;
  localparam logic [GUARD_W-1:0] GUARD_MAX  = 6'd40;
  localparam logic [USED_W-1:0]  USED_MAX   = 7'd64;

  typedef enum logic {
    REG_SYMBOL_COUNT = 1'b0,
    REG_ADAPTIVE     = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_TOT,
    ST_RD_HI,
    ST_RD_LO,
    ST_MUL_HI,
    ST_GO_HI,
    ST_WAIT_HI,
    ST_GO_LO,
    ST_WAIT_LO,
    ST_RENORM,
    ST_EMIT_FIRST,
    ST_EMIT_FOLLOW,
    ST_HALVE_START,
    ST_HALVE_RD,
    ST_HALVE_WR,
    ST_INC_START,
    ST_INC_WALK,
    ST_FLUSH,
    ST_FINISH
  } state_e;

endpackage

[rtl/aae_ram.sv]
// ----------------------------------------------------------------------------
// aae_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aae_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/aae_div.sv]
// ----------------------------------------------------------------------------
// aae_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aae_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [aae_pkg::PROD_W-1:0] dividend_i,
  input  logic [aae_pkg::FREQ_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [aae_pkg::PROD_W-1:0] quotient_o
);
  import aae_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  logic [PROD_W-1:0] quo_q, quo_d;
  logic [FREQ_W-1:0] rem_q, rem_d;
  logic [FREQ_W-1:0] div_q, div_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [FREQ_W:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[PROD_W-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift dividend bits out at the top, quotient bits in at the bottom
      if (trial >= {1'b0, div_q}) begin
        rem_d = FREQ_W'(trial - {1'b0, div_q});
        quo_d = {quo_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[FREQ_W-1:0];
        quo_d = {quo_q[PROD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/adaptive_arith_encoder_top.sv]
// ----------------------------------------------------------------------------
// adaptive_arith_encoder_top
// 16-bit adaptive arithmetic encoder packing code bits into one word.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_stall_o, symbol_i, last_i  | sink
//  out      | out_valid_o, out_stall_i, bits_used_o,    | source
//           | code_word_o, message_done_o, bad_symbol_o |
//  cfg      | psel, penable, pwrite, paddr, pwdata,     | APB slave
//           | prdata, pready                            |
//
// One symbol at a time: table reads, two divisions in the shared divider,
// renormalize steps with their emitted bits and closed follow runs, then,
// in adaptive mode, a model update over the frequency memories, preceded
// by a halving pass when the total has reached its limit.
// After reset and after each symbol_count write a clearing pass over all
// MAX_SYMBOLS+1 entries rewrites the model; no beat is taken meanwhile.
// A finished result waits in the output register under stall.
// ----------------------------------------------------------------------------
module adaptive_arith_encoder_top #(
  parameter int MAX_SYMBOLS = aae_pkg::MAX_SYMBOLS_DEF,
  parameter int WORD_BITS   = aae_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [aae_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [aae_pkg::USED_W-1:0]  bits_used_o,
  output logic [aae_pkg::CODE_W-1:0]  code_word_o,
  output logic                        message_done_o,
  output logic                        bad_symbol_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aae_pkg::PADDR_W-1:0] paddr,
  input  logic [aae_pkg::PDATA_W-1:0] pwdata,
  output logic [aae_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import aae_pkg::*;

  localparam int AW  = $clog2(MAX_SYMBOLS + 1);
  localparam int FAW = $clog2(MAX_SYMBOLS);
  localparam int CNT_RST = (SYMBOL_COUNT_RST > MAX_SYMBOLS) ? MAX_SYMBOLS : SYMBOL_COUNT_RST;

  state_e st_q, st_d;

  logic [SYM_W-1:0]     sym_q, sym_d;
  logic                 last_q, last_d;
  logic                 bad_q, bad_d;
  logic [BOUND_W-1:0]   low_q, low_d, high_q, high_d, pend_q, pend_d;
  logic [WORD_BITS-1:0] pack_q, pack_d;
  logic [USED_W-1:0]    left_q, left_d, written_q, written_d;
  logic [AW-1:0]        count_q, count_d;
  logic                 adaptive_q, adaptive_d;
  logic [FREQ_W-1:0]    total_q, total_d, chi_q, chi_d, clo_q, clo_d, acc_q, acc_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [BOUND_W-1:0]   hi_off_q, hi_off_d;
  logic [GUARD_W-1:0]   guard_q, guard_d;
  logic                 emit_bit_q, emit_bit_d, ret_flush_q, ret_flush_d;
  logic [AW-1:0]        idx_q, idx_d, ra_q, ra_d;
  logic                 rv_q, rv_d, fw_q, fw_d;
  logic                 out_valid_q, out_valid_d;
  logic [USED_W-1:0]    out_used_q, out_used_d;
  logic [CODE_W-1:0]    out_word_q, out_word_d;
  logic                 out_done_q, out_done_d, out_bad_q, out_bad_d;

  // memory ports
  logic              f_we, c_we;
  logic [FAW-1:0]    f_waddr, f_raddr;
  logic [AW-1:0]     c_waddr, c_raddr;
  logic [FREQ_W-1:0] f_wdata, c_wdata, f_rdata, c_rdata;

  logic                 div_start, div_done;
  logic [PROD_W-1:0]    div_quo;
  logic [RANGE_W-1:0]   range_w;
  logic [FREQ_W:0]      half_sum;
  logic [FREQ_W-1:0]    half_f;
  logic                 cfg_wr;
  logic [CNT_IN_W-1:0]  cfg_cnt;
  logic [AW-1:0]        cfg_cnt_clamped;
  logic [AW-1:0]        sym_a;
  logic [WORD_BITS-1:0] word_aligned;
  logic                 in_acc;
  logic                 put_ok;
  state_e               post_code;

  aae_ram #(.WIDTH(FREQ_W), .DEPTH(MAX_SYMBOLS)) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  aae_ram #(.WIDTH(FREQ_W), .DEPTH(MAX_SYMBOLS + 1)) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  aae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_cnt = pwdata[CNT_IN_W-1:0];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx_e'(paddr[2]) == REG_ADAPTIVE) ? PDATA_W'(adaptive_q)
                                                          : PDATA_W'(count_q);

  always_comb begin
    if (16'(cfg_cnt) < 16'(MIN_SYMBOLS)) begin
      cfg_cnt_clamped = AW'(MIN_SYMBOLS);
    end else if (16'(cfg_cnt) > 16'(MAX_SYMBOLS)) begin
      cfg_cnt_clamped = AW'(MAX_SYMBOLS);
    end else begin
      cfg_cnt_clamped = AW'(cfg_cnt);
    end
  end

  assign in_stall_o   = (st_q != ST_IDLE);
  assign in_acc       = in_valid_i & ~in_stall_o;
  assign range_w      = {1'b0, high_q} - {1'b0, low_q} + RANGE_W'(1);
  assign half_sum     = {1'b0, f_rdata} + (FREQ_W+1)'(1);
  assign half_f       = half_sum[FREQ_W:1];
  assign sym_a        = AW'(sym_q);
  assign word_aligned = pack_q << left_q;
  assign put_ok       = (left_q != '0);

  always_comb begin
    if (adaptive_q) begin
      post_code = (total_q == FREQ_LIMIT) ? ST_HALVE_START : ST_INC_START;
    end else begin
      post_code = last_q ? ST_FLUSH : ST_FINISH;
    end
  end

  always_comb begin
    st_d        = st_q;
    sym_d       = sym_q;
    last_d      = last_q;
    bad_d       = bad_q;
    low_d       = low_q;
    high_d      = high_q;
    pend_d      = pend_q;
    pack_d      = pack_q;
    left_d      = left_q;
    written_d   = written_q;
    count_d     = count_q;
    adaptive_d  = adaptive_q;
    total_d     = total_q;
    chi_d       = chi_q;
    clo_d       = clo_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    hi_off_d    = hi_off_q;
    guard_d     = guard_q;
    emit_bit_d  = emit_bit_q;
    ret_flush_d = ret_flush_q;
    idx_d       = idx_q;
    ra_d        = ra_q;
    rv_d        = rv_q;
    fw_d        = fw_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_used_d  = out_used_q;
    out_word_d  = out_word_q;
    out_done_d  = out_done_q;
    out_bad_d   = out_bad_q;
    f_we        = 1'b0;
    f_waddr     = '0;
    f_wdata     = '0;
    f_raddr     = '0;
    c_we        = 1'b0;
    c_waddr     = '0;
    c_wdata     = '0;
    c_raddr     = '0;
    div_start   = 1'b0;

    unique case (st_q)
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = idx_q;
        c_wdata = (idx_q < count_q) ? FREQ_W'(count_q - idx_q) : '0;
        f_we    = (idx_q < AW'(MAX_SYMBOLS));
        f_waddr = FAW'(idx_q);
        f_wdata = FREQ_W'(1);
        if (idx_q == AW'(MAX_SYMBOLS)) begin
          st_d = ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          sym_d  = symbol_i;
          last_d = last_i;
          bad_d  = (16'(symbol_i) >= 16'(count_q));
          if (16'(symbol_i) >= 16'(count_q)) begin
            st_d = last_i ? ST_FLUSH : ST_FINISH;
          end else begin
            st_d = ST_RD_TOT;
          end
        end
      end
      ST_RD_TOT: begin
        c_raddr = '0;
        st_d    = ST_RD_HI;
      end
      ST_RD_HI: begin
        total_d = (c_rdata == '0) ? FREQ_W'(1) : c_rdata;
        c_raddr = sym_a;
        st_d    = ST_RD_LO;
      end
      ST_RD_LO: begin
        chi_d   = c_rdata;
        c_raddr = sym_a + AW'(1);
        st_d    = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        clo_d  = c_rdata;
        prod_d = PROD_W'(range_w) * PROD_W'(chi_q);
        st_d   = ST_GO_HI;
      end
      ST_GO_HI: begin
        div_start = 1'b1;
        st_d      = ST_WAIT_HI;
      end
      ST_WAIT_HI: begin
        if (div_done) begin
          hi_off_d = div_quo[BOUND_W-1:0];
          prod_d   = PROD_W'(range_w) * PROD_W'(clo_q);
          st_d     = ST_GO_LO;
        end
      end
      ST_GO_LO: begin
        div_start = 1'b1;
        st_d      = ST_WAIT_LO;
      end
      ST_WAIT_LO: begin
        if (div_done) begin
          high_d  = low_q + hi_off_q - BOUND_W'(1);
          low_d   = low_q + div_quo[BOUND_W-1:0];
          guard_d = '0;
          st_d    = ST_RENORM;
        end
      end
      ST_RENORM: begin
        ret_flush_d = 1'b0;
        if (guard_q == GUARD_MAX) begin
          st_d = post_code;
        end else if (high_q < HALF_VAL) begin
          emit_bit_d = 1'b0;
          low_d      = {low_q[BOUND_W-2:0], 1'b0};
          high_d     = {high_q[BOUND_W-2:0], 1'b1};
          guard_d    = guard_q + GUARD_W'(1);
          st_d       = ST_EMIT_FIRST;
        end else if (low_q >= HALF_VAL) begin
          emit_bit_d = 1'b1;
          low_d      = {low_q[BOUND_W-2:0], 1'b0};
          high_d     = {high_q[BOUND_W-2:0], 1'b1};
          guard_d    = guard_q + GUARD_W'(1);
          st_d       = ST_EMIT_FIRST;
        end else if (low_q >= QTR1 && high_q < QTR3) begin
          // straddles the middle: defer the bit as a follow
          if (pend_q != TOP_VAL) begin
            pend_d = pend_q + BOUND_W'(1);
          end
          low_d   = {low_q[BOUND_W-2:0] ^ 1'b0, 1'b0} - {QTR1[BOUND_W-2:0], 1'b0};
          high_d  = {high_q[BOUND_W-2:0], 1'b1} - {QTR1[BOUND_W-2:0], 1'b0};
          guard_d = guard_q + GUARD_W'(1);
        end else begin
          st_d = post_code;
        end
      end
      ST_EMIT_FIRST: begin
        if (put_ok) begin
          pack_d    = {pack_q[WORD_BITS-2:0], emit_bit_q};
          left_d    = left_q - USED_W'(1);
          written_d = written_q + USED_W'(1);
        end
        st_d = ST_EMIT_FOLLOW;
      end
      ST_EMIT_FOLLOW: begin
        if (pend_q == '0 || !put_ok) begin
          pend_d = '0;
          st_d   = ret_flush_q ? ST_FINISH : ST_RENORM;
        end else begin
          pack_d    = {pack_q[WORD_BITS-2:0], ~emit_bit_q};
          left_d    = left_q - USED_W'(1);
          written_d = written_q + USED_W'(1);
          pend_d    = pend_q - BOUND_W'(1);
        end
      end
      ST_HALVE_START: begin
        c_we    = 1'b1;
        c_waddr = count_q;
        c_wdata = '0;
        idx_d   = count_q;
        acc_d   = '0;
        st_d    = ST_HALVE_RD;
      end
      ST_HALVE_RD: begin
        f_raddr = FAW'(idx_q - AW'(1));
        st_d    = ST_HALVE_WR;
      end
      ST_HALVE_WR: begin
        f_we    = 1'b1;
        f_waddr = FAW'(idx_q - AW'(1));
        f_wdata = half_f;
        c_we    = 1'b1;
        c_waddr = idx_q - AW'(1);
        c_wdata = acc_q + half_f;
        acc_d   = acc_q + half_f;
        idx_d   = idx_q - AW'(1);
        st_d    = (idx_q == AW'(1)) ? ST_INC_START : ST_HALVE_RD;
      end
      ST_INC_START: begin
        f_raddr = FAW'(sym_q);
        c_raddr = '0;
        rv_d    = 1'b1;
        ra_d    = '0;
        fw_d    = 1'b1;
        idx_d   = AW'(1);
        st_d    = ST_INC_WALK;
      end
      ST_INC_WALK: begin
        // read entry idx while writing back the one read in the cycle before
        fw_d = 1'b0;
        if (fw_q) begin
          f_we    = 1'b1;
          f_waddr = FAW'(sym_q);
          f_wdata = f_rdata + FREQ_W'(1);
        end
        if (rv_q) begin
          c_we    = 1'b1;
          c_waddr = ra_q;
          c_wdata = c_rdata + FREQ_W'(1);
        end
        if (idx_q <= sym_a) begin
          c_raddr = idx_q;
          rv_d    = 1'b1;
          ra_d    = idx_q;
          idx_d   = idx_q + AW'(1);
        end else begin
          rv_d = 1'b0;
        end
        if (!rv_q) begin
          st_d = last_q ? ST_FLUSH : ST_FINISH;
        end
      end
      ST_FLUSH: begin
        if (pend_q != TOP_VAL) begin
          pend_d = pend_q + BOUND_W'(1);
        end
        emit_bit_d  = (low_q >= QTR1);
        ret_flush_d = 1'b1;
        st_d        = ST_EMIT_FIRST;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_used_d  = written_q;
          out_word_d  = last_q ? CODE_W'(word_aligned) : '0;
          out_done_d  = last_q;
          out_bad_d   = bad_q;
          if (last_q) begin
            low_d     = '0;
            high_d    = TOP_VAL;
            pend_d    = '0;
            pack_d    = '0;
            left_d    = USED_W'(WORD_BITS);
            written_d = '0;
          end
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_SYMBOL_COUNT: begin
          count_d = cfg_cnt_clamped;
          idx_d   = '0;
          st_d    = ST_CLEAR;
        end
        REG_ADAPTIVE: begin
          adaptive_d = pwdata[0];
        end
        default: begin
          adaptive_d = adaptive_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      sym_q       <= '0;
      last_q      <= 1'b0;
      bad_q       <= 1'b0;
      low_q       <= '0;
      high_q      <= TOP_VAL;
      pend_q      <= '0;
      pack_q      <= '0;
      left_q      <= USED_W'(WORD_BITS);
      written_q   <= '0;
      count_q     <= AW'(CNT_RST);
      adaptive_q  <= 1'b1;
      total_q     <= FREQ_W'(1);
      chi_q       <= '0;
      clo_q       <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      hi_off_q    <= '0;
      guard_q     <= '0;
      emit_bit_q  <= 1'b0;
      ret_flush_q <= 1'b0;
      idx_q       <= '0;
      ra_q        <= '0;
      rv_q        <= 1'b0;
      fw_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_used_q  <= '0;
      out_word_q  <= '0;
      out_done_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      st_q        <= st_d;
      sym_q       <= sym_d;
      last_q      <= last_d;
      bad_q       <= bad_d;
      low_q       <= low_d;
      high_q      <= high_d;
      pend_q      <= pend_d;
      pack_q      <= pack_d;
      left_q      <= left_d;
      written_q   <= written_d;
      count_q     <= count_d;
      adaptive_q  <= adaptive_d;
      total_q     <= total_d;
      chi_q       <= chi_d;
      clo_q       <= clo_d;
      acc_q       <= acc_d;
      prod_q      <= prod_d;
      hi_off_q    <= hi_off_d;
      guard_q     <= guard_d;
      emit_bit_q  <= emit_bit_d;
      ret_flush_q <= ret_flush_d;
      idx_q       <= idx_d;
      ra_q        <= ra_d;
      rv_q        <= rv_d;
      fw_q        <= fw_d;
      out_valid_q <= out_valid_d;
      out_used_q  <= out_used_d;
      out_word_q  <= out_word_d;
      out_done_q  <= out_done_d;
      out_bad_q   <= out_bad_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bits_used_o    = out_used_q;
  assign code_word_o    = out_word_q;
  assign message_done_o = out_done_q;
  assign bad_symbol_o   = out_bad_q;

endmodule

[rtl/aae_checker.sv]
// ----------------------------------------------------------------------------
// aae_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module aae_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [aae_pkg::SYM_W-1:0]   symbol_i,
  input logic                        last_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [aae_pkg::USED_W-1:0]  bits_used_o,
  input logic [aae_pkg::CODE_W-1:0]  code_word_o,
  input logic                        message_done_o,
  input logic                        bad_symbol_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [aae_pkg::PADDR_W-1:0] paddr,
  input logic [aae_pkg::PDATA_W-1:0] pwdata,
  input logic [aae_pkg::PDATA_W-1:0] prdata,
  input logic                        pready
);
  import aae_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_word_o)
      && $stable(bits_used_o) && $stable(message_done_o) && $stable(bad_symbol_o))
    else $error("stalled result beat changed");

  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !message_done_o |-> code_word_o == '0)
    else $error("code word set on an unfinished message");

  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bits_used_o <= USED_MAX)
    else $error("bits used exceeds word size");

  // one symbol at a time: stall right after a taken beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second symbol taken while busy");

endmodule

bind adaptive_arith_encoder_top aae_checker u_aae_checker (.*);
